### hw/rtl/bhms_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and control words for the binned hit membership set.
package bhms_pkg;

  localparam int BUCKETS_DEF = 1024;
  localparam int WAYS_DEF    = 8;

  localparam int OP_W   = 2;
  localparam int CH_W   = 16;
  localparam int PT_W   = 20;
  localparam int FILL_W = 4;
  localparam int ENT_W  = CH_W + PT_W;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2
  } op_t;

  // channel / 50 as (channel * 83887) >> 22, exact over 16 bits
  localparam int                CH_RECIP_W = 17;
  localparam logic [CH_RECIP_W-1:0] CH_RECIP = 17'd83887;
  localparam int                CH_PROD_W  = CH_W + CH_RECIP_W;

  // peak_time / 4000 as ((peak_time >> 5) * 33555) >> 22, exact over 20 bits
  localparam int                PT_PRE     = 5;
  localparam int                PT_Q_W     = PT_W - PT_PRE;
  localparam int                PT_RECIP_W = 16;
  localparam logic [PT_RECIP_W-1:0] PT_RECIP = 16'd33555;
  localparam int                PT_PROD_W  = PT_Q_W + PT_RECIP_W;

  localparam int DIV_SHIFT = 22;
  localparam int X_W       = CH_PROD_W - DIV_SHIFT;
  localparam int Y_W       = PT_PROD_W - DIV_SHIFT;
  localparam int S_W       = 11;
  localparam int SQ_W      = 2 * S_W;
  localparam int CELL_W    = 21;

  typedef struct packed {
    logic load;
    logic div;
    logic pair;
    logic sq;
    logic cell_load;
    logic mod_step;
    logic fill_rd;
    logic fill_wr;
    logic sweep;
    logic scan_rd;
    logic scan_adv;
    logic res_load;
    logic res_found;
    logic res_dropped;
  } cmd_t;

  typedef struct packed {
    logic is_clear;
    logic is_insert;
    logic is_query;
    logic pow2;
    logic mod_last;
    logic sweep_last;
    logic full;
    logic scan_empty;
    logic scan_last;
    logic match;
    logic out_free;
  } sts_t;

endpackage

### hw/rtl/bhms_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for request and response words.
interface bhms_req_if;
  logic                        valid;
  logic                        ready;
  logic [bhms_pkg::OP_W-1:0]   op;
  logic [bhms_pkg::CH_W-1:0]   channel;
  logic [bhms_pkg::PT_W-1:0]   peak_time;

  modport source (output valid, op, channel, peak_time, input ready);
  modport sink   (input valid, op, channel, peak_time, output ready);
endinterface

interface bhms_rsp_if;
  logic valid;
  logic ready;
  logic found;
  logic dropped;

  modport source (output valid, found, dropped, input ready);
  modport sink   (input valid, found, dropped, output ready);
endinterface

### hw/rtl/binned_hit_membership_set_unit.sv
`timescale 1ns / 1ps
// Top level of the binned hit membership set: controller plus datapath.
// Insert and query go through a bucket reduction when BUCKETS is not a power of two,
// and a query reads and compares the bucket ways one at a time; the next word is taken
// right after the response word is loaded.
// Clear sweeps the fill-count memory, one entry cleared per cycle.
// After rst the fill-count memory is swept with ready low.
module binned_hit_membership_set_unit #(
  parameter int BUCKETS = bhms_pkg::BUCKETS_DEF,
  parameter int WAYS    = bhms_pkg::WAYS_DEF
) (
  input logic        clk,
  input logic        rst,
  bhms_req_if.sink   req,
  bhms_rsp_if.source rsp
);

  bhms_pkg::cmd_t cmd;
  bhms_pkg::sts_t sts;

  bhms_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bhms_datapath #(
    .BUCKETS (BUCKETS),
    .WAYS    (WAYS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .sts           (sts),
    .req_op        (req.op),
    .req_channel   (req.channel),
    .req_peak_time (req.peak_time),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_found     (rsp.found),
    .rsp_dropped   (rsp.dropped)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("word accepted while another is in work");

  a_fill_wr_room: assert property (@(posedge clk) disable iff (rst)
    cmd.fill_wr |-> !sts.full && sts.is_insert)
    else $error("entry written into a full bucket");

  a_res_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> sts.out_free)
    else $error("response word overwritten before taken");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.found && rsp.dropped))
    else $error("found and dropped both set");

endmodule

### hw/rtl/bhms_datapath.sv
`timescale 1ns / 1ps
// Datapath: cell number, bucket reduction, fill and entry memories, result register.
module bhms_datapath #(
  parameter int BUCKETS = bhms_pkg::BUCKETS_DEF,
  parameter int WAYS    = bhms_pkg::WAYS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bhms_pkg::cmd_t            cmd,
  output bhms_pkg::sts_t            sts,
  input  logic [bhms_pkg::OP_W-1:0] req_op,
  input  logic [bhms_pkg::CH_W-1:0] req_channel,
  input  logic [bhms_pkg::PT_W-1:0] req_peak_time,
  output logic                      rsp_valid,
  input  logic                      rsp_ready,
  output logic                      rsp_found,
  output logic                      rsp_dropped
);

  localparam int BLOG   = $clog2(BUCKETS);
  localparam bit POW2   = (BUCKETS == (1 << BLOG));
  localparam int MOD_K  = bhms_pkg::CELL_W - BLOG;
  localparam int K_W    = $clog2(MOD_K + 1);
  localparam int ADDR_W = $clog2(BUCKETS * WAYS);

  logic [bhms_pkg::OP_W-1:0]      op_r;
  logic [bhms_pkg::CH_W-1:0]      ch_r;
  logic [bhms_pkg::PT_W-1:0]      pt_r;
  logic [bhms_pkg::CH_PROD_W-1:0] prod_x;
  logic [bhms_pkg::PT_PROD_W-1:0] prod_y;
  logic [bhms_pkg::S_W-1:0]       s_r;
  logic [bhms_pkg::Y_W-1:0]       y_r;
  logic [bhms_pkg::SQ_W-1:0]      sq_r;
  logic [bhms_pkg::X_W-1:0]       x_c;
  logic [bhms_pkg::Y_W-1:0]       y_c;
  logic [bhms_pkg::CELL_W-1:0]    cell_c;
  logic [bhms_pkg::CELL_W-1:0]    rem;
  logic [bhms_pkg::CELL_W:0]      dsh;
  logic [K_W-1:0]                 kcnt;
  logic [BLOG-1:0]                bucket;
  logic [BLOG-1:0]                sweep_idx;
  logic [bhms_pkg::FILL_W-1:0]    fill_mem [BUCKETS];
  logic [bhms_pkg::FILL_W-1:0]    fill_rd;
  logic [bhms_pkg::FILL_W-1:0]    limit;
  logic [bhms_pkg::FILL_W-1:0]    way;
  logic [ADDR_W-1:0]              base;
  logic [ADDR_W-1:0]              ent_addr;
  logic [bhms_pkg::ENT_W-1:0]     ent_mem [BUCKETS * WAYS];
  logic [bhms_pkg::ENT_W-1:0]     ent_rd;

  assign x_c    = prod_x[bhms_pkg::CH_PROD_W-1:bhms_pkg::DIV_SHIFT] + 1'b1;
  assign y_c    = prod_y[bhms_pkg::PT_PROD_W-1:bhms_pkg::DIV_SHIFT] + 1'b1;
  assign cell_c = sq_r[bhms_pkg::SQ_W-1:1] + bhms_pkg::CELL_W'(y_r);
  assign dsh    = (bhms_pkg::CELL_W + 1)'(BUCKETS) << kcnt;
  assign bucket = rem[BLOG-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= req_op;
      ch_r <= req_channel;
      pt_r <= req_peak_time;
    end
    if (cmd.div) begin
      prod_x <= ch_r * bhms_pkg::CH_RECIP;
      prod_y <= pt_r[bhms_pkg::PT_W-1:bhms_pkg::PT_PRE] * bhms_pkg::PT_RECIP;
    end
    if (cmd.pair) begin
      s_r <= bhms_pkg::S_W'(x_c) + bhms_pkg::S_W'(y_c);
      y_r <= y_c;
    end
    if (cmd.sq) begin
      sq_r <= bhms_pkg::SQ_W'(s_r) * bhms_pkg::SQ_W'(s_r + 1'b1);
    end
  end

  // reduce the cell number modulo BUCKETS: a mask when BUCKETS is a power of two, else one shifted subtract a cycle
  always_ff @(posedge clk) begin
    if (cmd.cell_load) begin
      rem  <= POW2 ? (cell_c & bhms_pkg::CELL_W'(BUCKETS - 1)) : cell_c;
      kcnt <= K_W'(MOD_K);
    end else if (cmd.mod_step) begin
      if ({1'b0, rem} >= dsh) begin
        rem <= rem - dsh[bhms_pkg::CELL_W-1:0];
      end
      kcnt <= kcnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_idx <= '0;
    end else if (cmd.sweep) begin
      sweep_idx <= (sweep_idx == BLOG'(BUCKETS - 1)) ? '0 : sweep_idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      fill_mem[sweep_idx] <= '0;
    end else if (cmd.fill_wr) begin
      fill_mem[bucket] <= fill_rd + 1'b1;
    end
    if (cmd.fill_rd) begin
      fill_rd <= fill_mem[bucket];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_rd) begin
      base <= ADDR_W'(bucket * WAYS);
      way  <= '0;
    end else if (cmd.scan_adv) begin
      way <= way + 1'b1;
    end
  end

  assign ent_addr = base + (cmd.fill_wr ? ADDR_W'(fill_rd) : ADDR_W'(way));

  always_ff @(posedge clk) begin
    if (cmd.fill_wr) begin
      ent_mem[ent_addr] <= {ch_r, pt_r};
    end
    if (cmd.scan_rd) begin
      ent_rd <= ent_mem[ent_addr];
    end
  end

  assign limit = (fill_rd > bhms_pkg::FILL_W'(WAYS)) ? bhms_pkg::FILL_W'(WAYS) : fill_rd;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rsp_found   <= cmd.res_found;
      rsp_dropped <= cmd.res_dropped;
    end
  end

  always_comb begin
    sts.is_clear   = (op_r == bhms_pkg::OP_CLEAR);
    sts.is_insert  = (op_r == bhms_pkg::OP_INSERT);
    sts.is_query   = (op_r == bhms_pkg::OP_QUERY);
    sts.pow2       = POW2;
    sts.mod_last   = (kcnt == '0);
    sts.sweep_last = (sweep_idx == BLOG'(BUCKETS - 1));
    sts.full       = (fill_rd >= bhms_pkg::FILL_W'(WAYS));
    sts.scan_empty = (limit == '0);
    sts.scan_last  = (({1'b0, way} + 1'b1) >= {1'b0, limit});
    sts.match      = (ent_rd == {ch_r, pt_r});
    sts.out_free   = !rsp_valid || rsp_ready;
  end

endmodule

### hw/rtl/bhms_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine sequencing clear, insert and query words.
module bhms_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  bhms_pkg::sts_t sts,
  output bhms_pkg::cmd_t cmd
);

  typedef enum logic [12:0] {
    ST_INIT     = 13'b0000000000001,
    ST_IDLE     = 13'b0000000000010,
    ST_DIV      = 13'b0000000000100,
    ST_PAIR     = 13'b0000000001000,
    ST_SQ       = 13'b0000000010000,
    ST_CELL     = 13'b0000000100000,
    ST_MOD      = 13'b0000001000000,
    ST_FILL_RD  = 13'b0000010000000,
    ST_FILL_CHK = 13'b0000100000000,
    ST_SCAN_RD  = 13'b0001000000000,
    ST_SCAN_CMP = 13'b0010000000000,
    ST_CLEAR    = 13'b0100000000000,
    ST_RESULT   = 13'b1000000000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   found;
  logic   found_next;
  logic   dropped;
  logic   dropped_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    found   <= found_next;
    dropped <= dropped_next;
  end

  always_comb begin
    state_next   = state;
    found_next   = found;
    dropped_next = dropped;
    cmd          = '0;
    req_ready    = 1'b0;
    unique case (state)
      ST_INIT: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        found_next   = 1'b0;
        dropped_next = 1'b0;
        priority if (sts.is_clear) begin
          state_next = ST_CLEAR;
        end else if (sts.is_insert || sts.is_query) begin
          cmd.div    = 1'b1;
          state_next = ST_PAIR;
        end else begin
          state_next = ST_RESULT;
        end
      end
      ST_PAIR: begin
        cmd.pair   = 1'b1;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq     = 1'b1;
        state_next = ST_CELL;
      end
      ST_CELL: begin
        cmd.cell_load = 1'b1;
        state_next    = sts.pow2 ? ST_FILL_RD : ST_MOD;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (sts.mod_last) begin
          state_next = ST_FILL_RD;
        end
      end
      ST_FILL_RD: begin
        cmd.fill_rd = 1'b1;
        state_next  = ST_FILL_CHK;
      end
      ST_FILL_CHK: begin
        priority if (sts.is_insert) begin
          if (sts.full) begin
            dropped_next = 1'b1;
          end else begin
            cmd.fill_wr = 1'b1;
          end
          state_next = ST_RESULT;
        end else if (sts.scan_empty) begin
          state_next = ST_RESULT;
        end else begin
          state_next = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        cmd.scan_rd = 1'b1;
        state_next  = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        priority if (sts.match) begin
          found_next = 1'b1;
          state_next = ST_RESULT;
        end else if (sts.scan_last) begin
          state_next = ST_RESULT;
        end else begin
          cmd.scan_adv = 1'b1;
          state_next   = ST_SCAN_RD;
        end
      end
      ST_CLEAR: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = ST_RESULT;
        end
      end
      ST_RESULT: begin
        if (sts.out_free) begin
          cmd.res_load    = 1'b1;
          cmd.res_found   = found;
          cmd.res_dropped = dropped;
          state_next      = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_INIT;
      end
    endcase
  end

endmodule

### test/tb_binned_hit_membership_set_unit.sv
`timescale 1ns / 1ps
// Testbench for binned_hit_membership_set_unit: directed and random hit traffic.
module tb_binned_hit_membership_set_unit;

  localparam int NUM_BUCKETS    = bhms_pkg::BUCKETS_DEF;
  localparam int NUM_WAYS       = bhms_pkg::WAYS_DEF;
  localparam int CELL_CHANNELS  = 50;
  localparam int CELL_TICKS     = 250;
  localparam int TICK_STEPS     = 16;
  localparam int CELL_SPAN      = CELL_TICKS * TICK_STEPS;
  localparam logic [bhms_pkg::CH_W-1:0] CH_MAX = '1;
  localparam logic [bhms_pkg::PT_W-1:0] PT_MAX = '1;
  localparam int MAX_COL        = int'(CH_MAX) / CELL_CHANNELS;
  localparam int MAX_ROW        = int'(PT_MAX) / CELL_SPAN;
  localparam logic [bhms_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_WORDS   = 500;
  localparam int POOL_CELLS     = 8;
  localparam int HISTORY_DEPTH  = 64;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [bhms_pkg::OP_W-1:0] op;
    logic [bhms_pkg::CH_W-1:0] channel;
    logic [bhms_pkg::PT_W-1:0] peak_time;
    logic                      found;
    logic                      dropped;
  } hit_word_t;

  typedef struct packed {
    logic [bhms_pkg::CH_W-1:0] channel;
    logic [bhms_pkg::PT_W-1:0] peak_time;
  } hit_t;

  logic clk;
  logic rst;

  bhms_req_if req_bus ();
  bhms_rsp_if rsp_bus ();

  binned_hit_membership_set_unit uut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  logic [bhms_pkg::FILL_W-1:0] fill_count [NUM_BUCKETS];
  logic [bhms_pkg::CH_W-1:0]   way_channel [NUM_BUCKETS*NUM_WAYS];
  logic [bhms_pkg::PT_W-1:0]   way_time [NUM_BUCKETS*NUM_WAYS];

  hit_word_t pending_results [$];
  hit_t      hit_history [$];
  int        pool_col [POOL_CELLS];
  int        pool_row [POOL_CELLS];
  int        mismatches;
  int        idle_cycles;
  int        burst_left;
  logic [15:0] sink_cycle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int bucket_index(logic [bhms_pkg::CH_W-1:0] channel,
                                       logic [bhms_pkg::PT_W-1:0] peak_time);
    int col;
    int row;
    int diag;
    col  = int'(channel) / CELL_CHANNELS + 1;
    row  = int'(peak_time) / CELL_SPAN + 1;
    diag = col + row;
    return ((diag * (diag + 1)) / 2 + row) % NUM_BUCKETS;
  endfunction

  function automatic hit_word_t predict_word(logic [bhms_pkg::OP_W-1:0] op,
                                             logic [bhms_pkg::CH_W-1:0] channel,
                                             logic [bhms_pkg::PT_W-1:0] peak_time);
    hit_word_t w;
    int        b;
    int        fill;
    int        idx;
    w.op        = op;
    w.channel   = channel;
    w.peak_time = peak_time;
    w.found     = 1'b0;
    w.dropped   = 1'b0;
    b    = bucket_index(channel, peak_time);
    fill = int'(fill_count[b]);
    case (op)
      bhms_pkg::OP_CLEAR: begin
        for (idx = 0; idx < NUM_BUCKETS; idx++) fill_count[idx] = '0;
      end
      bhms_pkg::OP_INSERT: begin
        if (fill < NUM_WAYS) begin
          way_channel[b*NUM_WAYS+fill] = channel;
          way_time[b*NUM_WAYS+fill]    = peak_time;
          fill_count[b]                = bhms_pkg::FILL_W'(fill + 1);
        end else begin
          w.dropped = 1'b1;
        end
      end
      bhms_pkg::OP_QUERY: begin
        for (idx = 0; idx < fill && idx < NUM_WAYS; idx++) begin
          if (way_channel[b*NUM_WAYS+idx] == channel && way_time[b*NUM_WAYS+idx] == peak_time)
            w.found = 1'b1;
        end
      end
      default: ;
    endcase
    return w;
  endfunction

  function automatic hit_t hit_in_cell(int col, int row);
    hit_t h;
    int   ch;
    int   pt;
    ch = col * CELL_CHANNELS + int'($urandom_range(0, CELL_CHANNELS - 1));
    pt = row * CELL_SPAN + int'($urandom_range(0, CELL_SPAN - 1));
    h.channel   = (ch > int'(CH_MAX)) ? CH_MAX : bhms_pkg::CH_W'(ch);
    h.peak_time = (pt > int'(PT_MAX)) ? PT_MAX : bhms_pkg::PT_W'(pt);
    return h;
  endfunction

  task automatic renew_cell(input int slot);
    pool_col[slot] = ($urandom_range(0, 7) == 0) ? MAX_COL * $urandom_range(0, 1)
                                                  : $urandom_range(0, MAX_COL);
    pool_row[slot] = ($urandom_range(0, 7) == 0) ? MAX_ROW * $urandom_range(0, 1)
                                                  : $urandom_range(0, MAX_ROW);
  endtask

  task automatic send_hit(input logic [bhms_pkg::OP_W-1:0] op,
                          input logic [bhms_pkg::CH_W-1:0] channel,
                          input logic [bhms_pkg::PT_W-1:0] peak_time);
    int   gap;
    hit_t h;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 8);
      repeat (gap) begin
        @(negedge clk);
        req_bus.valid <= 1'b0;
      end
      burst_left = ($urandom_range(0, 3) == 0) ? 64 : $urandom_range(1, 16);
    end
    @(negedge clk);
    req_bus.valid     <= 1'b1;
    req_bus.op        <= op;
    req_bus.channel   <= channel;
    req_bus.peak_time <= peak_time;
    do @(posedge clk); while (req_bus.ready !== 1'b1);
    pending_results = {pending_results, predict_word(op, channel, peak_time)};
    burst_left--;
    if (op == bhms_pkg::OP_INSERT) begin
      h.channel   = channel;
      h.peak_time = peak_time;
      hit_history = {hit_history, h};
      if (hit_history.size() > HISTORY_DEPTH) void'(hit_history.pop_front());
    end
  endtask

  task automatic wait_for_results;
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_extremes;
    send_hit(bhms_pkg::OP_INSERT, '0, '0);
    send_hit(bhms_pkg::OP_INSERT, CH_MAX, PT_MAX);
    send_hit(bhms_pkg::OP_QUERY, '0, '0);
    send_hit(bhms_pkg::OP_QUERY, CH_MAX, PT_MAX);
    send_hit(bhms_pkg::OP_QUERY, 16'd1, '0);
    send_hit(bhms_pkg::OP_QUERY, '0, 20'd1);
  endtask

  task automatic test_full_bucket;
    hit_t first;
    hit_t extra;
    first = hit_in_cell(3, 5);
    send_hit(bhms_pkg::OP_INSERT, first.channel, first.peak_time);
    send_hit(bhms_pkg::OP_INSERT, first.channel, first.peak_time);
    repeat (NUM_WAYS - 2) begin
      extra = hit_in_cell(3, 5);
      send_hit(bhms_pkg::OP_INSERT, extra.channel, extra.peak_time);
    end
    extra = hit_in_cell(3, 5);
    send_hit(bhms_pkg::OP_INSERT, extra.channel, extra.peak_time);
    send_hit(bhms_pkg::OP_QUERY, extra.channel, extra.peak_time);
    send_hit(bhms_pkg::OP_QUERY, first.channel, first.peak_time);
  endtask

  task automatic test_clear;
    wait_for_results;
    send_hit(bhms_pkg::OP_CLEAR, CH_MAX, PT_MAX);
    send_hit(bhms_pkg::OP_QUERY, '0, '0);
    send_hit(bhms_pkg::OP_INSERT, '0, '0);
    send_hit(bhms_pkg::OP_QUERY, '0, '0);
    send_hit(bhms_pkg::OP_QUERY, CH_MAX, PT_MAX);
  endtask

  task automatic test_unused_op;
    send_hit(OP_UNUSED, CH_MAX, PT_MAX);
    send_hit(bhms_pkg::OP_QUERY, '0, '0);
  endtask

  task automatic test_random_traffic;
    int   sent;
    int   pick;
    int   slot;
    hit_t h;
    for (slot = 0; slot < POOL_CELLS; slot++) renew_cell(slot);
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        if ($urandom_range(0, 1) == 1) wait_for_results;
        send_hit(bhms_pkg::OP_CLEAR, bhms_pkg::CH_W'($urandom), bhms_pkg::PT_W'($urandom));
        sent++;
      end else if (pick < 10) begin
        send_hit(bhms_pkg::OP_W'($urandom_range(1, 3)), bhms_pkg::CH_W'($urandom),
                 bhms_pkg::PT_W'($urandom));
        sent++;
      end else begin
        slot = $urandom_range(0, POOL_CELLS - 1);
        if ($urandom_range(0, 15) == 0) renew_cell(slot);
        repeat ($urandom_range(1, 4)) begin
          h = hit_in_cell(pool_col[slot], pool_row[slot]);
          send_hit(bhms_pkg::OP_INSERT, h.channel, h.peak_time);
          sent++;
        end
        h = hit_history[$urandom_range(0, hit_history.size() - 1)];
        send_hit(bhms_pkg::OP_QUERY, h.channel, h.peak_time);
        case ($urandom_range(0, 2))
          0: h.channel[$urandom_range(0, bhms_pkg::CH_W - 1)] ^= 1'b1;
          1: h.peak_time[$urandom_range(0, bhms_pkg::PT_W - 1)] ^= 1'b1;
          default: h = hit_in_cell(pool_col[slot], pool_row[slot]);
        endcase
        send_hit(bhms_pkg::OP_QUERY, h.channel, h.peak_time);
        sent += 2;
      end
    end
  endtask

  always @(negedge clk) begin
    sink_cycle <= sink_cycle + 1'b1;
    case (sink_cycle[9:8])
      2'd0: rsp_bus.ready <= 1'b1;
      2'd1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
      2'd2: rsp_bus.ready <= (sink_cycle[2:0] < 3'd5);
      default: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
    endcase
  end

  always @(posedge clk) begin : check_results
    hit_word_t want;
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected response word: found=%0b dropped=%0b",
                   rsp_bus.found, rsp_bus.dropped);
      end else begin
        want = pending_results.pop_front();
        if (rsp_bus.found !== want.found) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("found mismatch op=%0d ch=%0d pt=%0d: expected %0b, actual %0b",
                     want.op, want.channel, want.peak_time, want.found, rsp_bus.found);
        end
        if (rsp_bus.dropped !== want.dropped) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("dropped mismatch op=%0d ch=%0d pt=%0d: expected %0b, actual %0b",
                     want.op, want.channel, want.peak_time, want.dropped, rsp_bus.dropped);
        end
      end
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no word accepted for %0d cycles", idle_cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int idx;
    rst               = 1'b1;
    req_bus.valid     = 1'b0;
    req_bus.op        = bhms_pkg::OP_CLEAR;
    req_bus.channel   = '0;
    req_bus.peak_time = '0;
    rsp_bus.ready     = 1'b0;
    sink_cycle        = '0;
    mismatches        = 0;
    idle_cycles       = 0;
    burst_left        = 0;
    for (idx = 0; idx < NUM_BUCKETS; idx++) fill_count[idx] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_extremes;
    test_full_bucket;
    test_clear;
    test_unused_op;
    test_random_traffic;

    wait_for_results;
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

### binned_hit_membership_set_unit.f
hw/rtl/bhms_pkg.sv
hw/rtl/bhms_if.sv
hw/rtl/bhms_datapath.sv
hw/rtl/bhms_ctrl.sv
hw/rtl/binned_hit_membership_set_unit.sv
test/tb_binned_hit_membership_set_unit.sv
